### hdl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation and status codes, sequencer step codes and the
// command and status structs between controller and datapath.
// ---------------------------------------------------------------------------
package rau_pkg;

  localparam int WIDTH = 32;
  localparam int FW    = 32;
  localparam logic [FW-1:0] OP_MASK = 32'hFFFF_FFFF >> (FW - WIDTH);

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 72;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef logic [4:0] step_t;

  localparam step_t STP_LOAD = 5'd0;
  localparam step_t STP_GA   = 5'd1;
  localparam step_t STP_DNA  = 5'd2;
  localparam step_t STP_DDA  = 5'd3;
  localparam step_t STP_GB   = 5'd4;
  localparam step_t STP_DNB  = 5'd5;
  localparam step_t STP_DDB  = 5'd6;
  localparam step_t STP_FIX  = 5'd7;
  localparam step_t STP_GL   = 5'd8;
  localparam step_t STP_DQ1  = 5'd9;
  localparam step_t STP_DQ2  = 5'd10;
  localparam step_t STP_MXA  = 5'd11;
  localparam step_t STP_MXB  = 5'd12;
  localparam step_t STP_ADD  = 5'd13;
  localparam step_t STP_DR   = 5'd14;
  localparam step_t STP_G2   = 5'd15;
  localparam step_t STP_DT   = 5'd16;
  localparam step_t STP_DDG  = 5'd17;
  localparam step_t STP_MDN  = 5'd18;
  localparam step_t STP_G1   = 5'd19;
  localparam step_t STP_GM2  = 5'd20;
  localparam step_t STP_DP1  = 5'd21;
  localparam step_t STP_DP2  = 5'd22;
  localparam step_t STP_MNM  = 5'd23;
  localparam step_t STP_DP3  = 5'd24;
  localparam step_t STP_DP4  = 5'd25;
  localparam step_t STP_MDM  = 5'd26;
  localparam step_t STP_FIN  = 5'd27;

  typedef logic [1:0] unit_t;

  localparam unit_t U_ACT = 2'd0;
  localparam unit_t U_GCD = 2'd1;
  localparam unit_t U_DIV = 2'd2;
  localparam unit_t U_OUT = 2'd3;

  typedef struct packed {
    step_t step;
    logic  go;
    logic  wb;
  } rau_cmd_t;

  typedef struct packed {
    logic done;
    logic addsub;
  } rau_sts_t;

  function automatic unit_t unit_of(input step_t s);
    unit_t u;
    case (s)
      STP_GA, STP_GB, STP_GL, STP_G2, STP_G1, STP_GM2: u = U_GCD;
      STP_DNA, STP_DDA, STP_DNB, STP_DDB, STP_DQ1, STP_DQ2, STP_DR, STP_DT,
      STP_DDG, STP_DP1, STP_DP2, STP_DP3, STP_DP4: u = U_DIV;
      STP_FIN: u = U_OUT;
      default: u = U_ACT;
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

### hdl/rau_gcd.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Rational arithmetic unit: gcd engine
// Binary gcd, one compare and subtract or shift per cycle.
// ---------------------------------------------------------------------------
module rau_gcd (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    go,
  input  wire [rau_pkg::FW-1:0]  x,
  input  wire [rau_pkg::FW-1:0]  y,
  output logic                   busy,
  output logic [rau_pkg::FW-1:0] res
);
  import rau_pkg::*;

  logic          busy_r;
  logic [FW-1:0] u_r;
  logic [FW-1:0] v_r;
  logic [4:0]    k_r;
  logic [FW-1:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (go) begin
      if (x == '0) begin
        res_r  <= y;
        busy_r <= 1'b0;
      end else if (y == '0) begin
        res_r  <= x;
        busy_r <= 1'b0;
      end else begin
        u_r    <= x;
        v_r    <= y;
        k_r    <= '0;
        busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      if (u_r == v_r) begin
        res_r  <= u_r << k_r;
        busy_r <= 1'b0;
      end else if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + 5'd1;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r > v_r) begin
        u_r <= u_r - v_r;
      end else begin
        v_r <= v_r - u_r;
      end
    end
  end

  assign busy = busy_r;
  assign res  = res_r;

endmodule
`default_nettype wire

### hdl/rau_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Rational arithmetic unit: divider
// Restoring divider, one quotient bit per cycle; 32 or 64 dividend bits.
// ---------------------------------------------------------------------------
module rau_div (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      go,
  input  wire [2*rau_pkg::FW-1:0]  num,
  input  wire [rau_pkg::FW-1:0]    den,
  input  wire                      short_div,
  output logic                     busy,
  output logic [2*rau_pkg::FW-1:0] quo,
  output logic [rau_pkg::FW-1:0]   rem
);
  import rau_pkg::*;

  logic            busy_r;
  logic [6:0]      cnt_r;
  logic [2*FW-1:0] quo_r;
  logic [FW-1:0]   rem_r;
  logic [FW-1:0]   den_r;
  logic [FW:0]     rem_sh;
  logic            ge;

  assign rem_sh = {rem_r, quo_r[2*FW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (go) begin
      rem_r  <= '0;
      den_r  <= den;
      quo_r  <= short_div ? {num[FW-1:0], {FW{1'b0}}} : num;
      cnt_r  <= short_div ? 7'd32 : 7'd64;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh[FW-1:0] - den_r : rem_sh[FW-1:0];
      quo_r <= {quo_r[2*FW-2:0], ge};
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

### hdl/rau_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Rational arithmetic unit: controller
// Step sequencer: issue each step, wait for its unit, write back, advance.
// ---------------------------------------------------------------------------
module rau_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  rau_pkg::rau_sts_t   sts,
  output rau_pkg::rau_cmd_t   cmd
);
  import rau_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  step_t      step_r;
  step_t      step_nxt;
  step_t      follow;

  always_comb begin
    case (step_r)
      STP_GA:  follow = STP_DNA;
      STP_DNA: follow = STP_DDA;
      STP_DDA: follow = STP_GB;
      STP_GB:  follow = STP_DNB;
      STP_DNB: follow = STP_DDB;
      STP_DDB: follow = STP_FIX;
      STP_FIX: follow = sts.addsub ? STP_GL : STP_G1;
      STP_GL:  follow = STP_DQ1;
      STP_DQ1: follow = STP_DQ2;
      STP_DQ2: follow = STP_MXA;
      STP_MXA: follow = STP_MXB;
      STP_MXB: follow = STP_ADD;
      STP_ADD: follow = STP_DR;
      STP_DR:  follow = STP_G2;
      STP_G2:  follow = STP_DT;
      STP_DT:  follow = STP_DDG;
      STP_DDG: follow = STP_MDN;
      STP_G1:  follow = STP_GM2;
      STP_GM2: follow = STP_DP1;
      STP_DP1: follow = STP_DP2;
      STP_DP2: follow = STP_MNM;
      STP_MNM: follow = STP_DP3;
      STP_DP3: follow = STP_DP4;
      STP_DP4: follow = STP_MDM;
      default: follow = STP_FIN;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd.step  = step_r;
    cmd.go    = 1'b0;
    cmd.wb    = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.step  = STP_LOAD;
        if (in_tvalid) begin
          cmd.wb    = 1'b1;
          step_nxt  = STP_GA;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.go    = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.done) begin
          cmd.wb = 1'b1;
          if (step_r == STP_FIN) begin
            state_nxt = S_IDLE;
          end else begin
            step_nxt  = follow;
            state_nxt = S_ISSUE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= STP_LOAD;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/rau_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Rational arithmetic unit: datapath
// Operand registers, gcd engine, divider, multiplier and output register.
// ---------------------------------------------------------------------------
module rau_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  rau_pkg::rau_cmd_t                cmd,
  output rau_pkg::rau_sts_t                sts,
  input  wire [rau_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire [1:0]                        in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [rau_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [1:0]                       out_tuser
);
  import rau_pkg::*;

  logic [1:0]      op_r;
  logic            sa_r;
  logic            sb_r;
  logic [FW-1:0]   na_r;
  logic [FW-1:0]   da_r;
  logic [FW-1:0]   nb_r;
  logic [FW-1:0]   db_r;
  logic [FW-1:0]   g_r;
  logic [FW-1:0]   ga_r;
  logic [FW-1:0]   qa_r;
  logic [FW-1:0]   qb_r;
  logic [2*FW:0]   t_r;
  logic [2*FW-1:0] num_r;
  logic [2*FW-1:0] den_r;
  logic            neg_r;
  logic [1:0]      status_r;
  logic            out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [1:0]      out_user_r;

  logic [FW-1:0]   ld_na;
  logic [FW-1:0]   ld_da;
  logic [FW-1:0]   ld_nb;
  logic [FW-1:0]   ld_db;

  unit_t           unit;
  logic [FW-1:0]   gcd_x;
  logic [FW-1:0]   gcd_y;
  logic            gcd_busy;
  logic [FW-1:0]   gcd_res;
  logic [2*FW-1:0] div_num;
  logic [FW-1:0]   div_den;
  logic            div_short;
  logic            div_busy;
  logic [2*FW-1:0] div_quo;
  logic [FW-1:0]   div_rem;
  logic [FW-1:0]   mul_a;
  logic [FW-1:0]   mul_b;
  logic [2*FW-1:0] mul_p;

  logic [2*FW:0]   add_t;
  logic            add_neg;
  logic            sb_fix;

  assign ld_na = in_tdata[32:1] & OP_MASK;
  assign ld_da = in_tdata[64:33] & OP_MASK;
  assign ld_nb = in_tdata[97:66] & OP_MASK;
  assign ld_db = in_tdata[129:98] & OP_MASK;

  assign unit = unit_of(cmd.step);

  always_comb begin
    gcd_x     = na_r;
    gcd_y     = da_r;
    div_num   = {{FW{1'b0}}, na_r};
    div_den   = g_r;
    div_short = 1'b1;
    mul_a     = qa_r;
    mul_b     = qb_r;
    case (cmd.step)
      STP_GB:  begin gcd_x = nb_r; gcd_y = db_r; end
      STP_GL:  begin gcd_x = da_r; gcd_y = db_r; end
      STP_G2:  begin gcd_x = ga_r; gcd_y = g_r; end
      STP_G1:  begin gcd_x = na_r; gcd_y = db_r; end
      STP_GM2: begin gcd_x = nb_r; gcd_y = da_r; end
      STP_DDA: div_num = {{FW{1'b0}}, da_r};
      STP_DNB: div_num = {{FW{1'b0}}, nb_r};
      STP_DDB: div_num = {{FW{1'b0}}, db_r};
      STP_DQ1: div_num = {{FW{1'b0}}, db_r};
      STP_DQ2: div_num = {{FW{1'b0}}, da_r};
      STP_DR: begin
        div_num   = t_r[2*FW-1:0];
        div_short = 1'b0;
      end
      STP_DT: begin
        div_num   = t_r[2*FW-1:0];
        div_den   = ga_r;
        div_short = 1'b0;
      end
      STP_DDG: begin div_num = {{FW{1'b0}}, db_r}; div_den = ga_r; end
      STP_DP2: begin div_num = {{FW{1'b0}}, nb_r}; div_den = ga_r; end
      STP_DP3: begin div_num = {{FW{1'b0}}, da_r}; div_den = ga_r; end
      STP_DP4: div_num = {{FW{1'b0}}, db_r};
      STP_MXA: begin mul_a = na_r; mul_b = qa_r; end
      STP_MXB: begin mul_a = nb_r; mul_b = qb_r; end
      default: ;
    endcase
  end

  assign mul_p = {{FW{1'b0}}, mul_a} * {{FW{1'b0}}, mul_b};

  always_comb begin
    if (sa_r == sb_r) begin
      add_t   = {1'b0, num_r} + {1'b0, den_r};
      add_neg = sa_r;
    end else if (num_r > den_r) begin
      add_t   = {1'b0, num_r - den_r};
      add_neg = sa_r;
    end else if (den_r > num_r) begin
      add_t   = {1'b0, den_r - num_r};
      add_neg = sb_r;
    end else begin
      add_t   = '0;
      add_neg = 1'b0;
    end
  end

  assign sb_fix = (nb_r == '0) ? 1'b0 : sb_r;

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.go && (unit == U_GCD)),
    .x     (gcd_x),
    .y     (gcd_y),
    .busy  (gcd_busy),
    .res   (gcd_res)
  );

  rau_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (cmd.go && (unit == U_DIV)),
    .num       (div_num),
    .den       (div_den),
    .short_div (div_short),
    .busy      (div_busy),
    .quo       (div_quo),
    .rem       (div_rem)
  );

  always_comb begin
    case (unit)
      U_GCD:   sts.done = !gcd_busy;
      U_DIV:   sts.done = !div_busy;
      U_OUT:   sts.done = !out_valid_r;
      default: sts.done = 1'b1;
    endcase
    sts.addsub = (op_r == OP_ADD) || (op_r == OP_SUB);
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      case (cmd.step)
        STP_LOAD: begin
          op_r     <= in_tuser;
          sa_r     <= in_tdata[0];
          na_r     <= ld_na;
          da_r     <= ld_da;
          sb_r     <= in_tdata[65];
          nb_r     <= ld_nb;
          db_r     <= ld_db;
          status_r <= (ld_da == '0 || ld_db == '0) ? ST_DZ : ST_OK;
        end
        STP_GA, STP_GB, STP_GL, STP_G1: g_r <= gcd_res;
        STP_G2, STP_GM2:                ga_r <= gcd_res;
        STP_DNA:                        na_r <= div_quo[FW-1:0];
        STP_DDA:                        da_r <= div_quo[FW-1:0];
        STP_DNB:                        nb_r <= div_quo[FW-1:0];
        STP_DDB:                        db_r <= div_quo[FW-1:0];
        STP_FIX: begin
          if (na_r == '0) begin
            sa_r <= 1'b0;
          end
          case (op_r)
            OP_SUB: sb_r <= sb_fix ^ (nb_r != '0);
            OP_DIV: begin
              sb_r <= sb_fix;
              if (nb_r == '0) begin
                if (status_r == ST_OK) begin
                  status_r <= ST_DZ;
                end
              end else begin
                nb_r <= db_r;
                db_r <= nb_r;
              end
            end
            default: sb_r <= sb_fix;
          endcase
        end
        STP_DQ1, STP_DDG, STP_DP1, STP_DP3: qa_r <= div_quo[FW-1:0];
        STP_DQ2, STP_DP2, STP_DP4:          qb_r <= div_quo[FW-1:0];
        STP_MXA:                            num_r <= mul_p;
        STP_MXB, STP_MDN, STP_MDM:          den_r <= mul_p;
        STP_ADD: begin
          t_r   <= add_t;
          neg_r <= add_neg;
          if (add_t[2*FW] && status_r == ST_OK) begin
            status_r <= ST_OVF;
          end
        end
        STP_DR:  ga_r  <= div_rem;
        STP_DT:  num_r <= div_quo;
        STP_MNM: begin
          num_r <= mul_p;
          neg_r <= sa_r ^ sb_r;
        end
        STP_FIN: begin
          if (status_r != ST_OK) begin
            out_data_r <= {{(OUT_TDATA_W-65){1'b0}}, 32'd1, 32'd0, 1'b0};
            out_user_r <= status_r;
          end else if (num_r == '0) begin
            out_data_r <= {{(OUT_TDATA_W-65){1'b0}}, 32'd1, 32'd0, 1'b0};
            out_user_r <= ST_OK;
          end else if (num_r > {{FW{1'b0}}, OP_MASK} || den_r > {{FW{1'b0}}, OP_MASK}) begin
            out_data_r <= {{(OUT_TDATA_W-65){1'b0}}, 32'd1, 32'd0, 1'b0};
            out_user_r <= ST_OVF;
          end else begin
            out_data_r <= {{(OUT_TDATA_W-65){1'b0}}, den_r[FW-1:0], num_r[FW-1:0], neg_r};
            out_user_r <= ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wb && cmd.step == STP_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

### hdl/rational_arithmetic_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Rational arithmetic unit core
// Add, subtract, multiply or divide two sign-magnitude rationals and return
// the fully reduced result with a status code.
//
//   channel  dir  width  content
//   in_      in   136+2  operands in tdata, operation in tuser
//   out_     out  72+2   reduced result in tdata, status in tuser
//
// One transaction at a time, its length set by the binary gcd engine (one
// shift or subtract a cycle) and the one-bit-a-cycle divider.
// in_tready is high only while the sequencer is idle.
// A finished result waits in the output register; a stalled out_ side holds
// the sequencer at its last step. Reset is synchronous, active low.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit_core (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // [0] a_negative, [32:1] a_numerator, [64:33] a_denominator,
  // [65] b_negative, [97:66] b_numerator, [129:98] b_denominator
  input  wire [rau_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] operation
  input  wire [1:0]                        in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [0] result_negative, [32:1] result_numerator, [64:33] result_denominator
  output logic [rau_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [1:0]                       out_tuser
);
  import rau_pkg::*;

  rau_cmd_t cmd;
  rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rau_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

### hdl/rau_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level properties of the core, attached by bind.
// ---------------------------------------------------------------------------
module rau_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [rau_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire [1:0]                        out_tuser
);
  import rau_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while busy");

  a_err_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[64:33] == 32'd1 && out_tdata[32:0] == '0)
    else $error("flagged result not normalised");

  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32:1] == '0 |-> !out_tdata[0] && out_tdata[64:33] == 32'd1)
    else $error("zero result not positive 0/1");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[64:33] != '0)
    else $error("zero denominator in result");

endmodule

bind rational_arithmetic_unit_core rau_chk u_rau_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
